>>> rtl/gce_pkg.sv
package gce_pkg;

    localparam int Q_FRAC_BITS = 16;
    localparam int GINI_W      = 17;
    localparam int COUNT_OUT_W = 7;
    localparam int IN_W        = 24;
    localparam int FIFO_DEPTH  = 4;
    localparam logic [GINI_W-1:0] Q_ONE = 17'h10000;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SWEEP,
        B_FLUSH,
        B_MUL,
        B_CHK,
        B_DIV,
        B_OUT
    } back_state_t;

endpackage

>>> rtl/gce_front.sv
module gce_front
    import gce_pkg::*;
#(
    parameter int MAX_SAMPLES = 64,
    parameter int SAMPLE_BITS = 23,
    parameter int CW          = $clog2(MAX_SAMPLES + 1),
    parameter int EW          = SAMPLE_BITS + 3
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [IN_W-1:0] sample,
    input  logic            last,
    output logic            ent_push,
    output logic [EW-1:0]   ent_data
);
    localparam logic [63:0] SMAX = (64'(1) << SAMPLE_BITS) - 64'(1);

    logic [CW-1:0]          count_reg, count_next;
    logic                   ovf_reg, ovf_next;
    logic                   drop;
    logic [SAMPLE_BITS-1:0] value;

    // negatives count as zero, wide values saturate
    always_comb
    begin
        if (sample[IN_W-1])
            value = '0;
        else if (64'(sample) > SMAX)
            value = SAMPLE_BITS'(SMAX);
        else
            value = SAMPLE_BITS'(sample);
    end

    assign drop = (count_reg == CW'(MAX_SAMPLES));

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (accept)
        begin
            if (last)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                count_next = drop ? count_reg : count_reg + CW'(1);
                ovf_next   = ovf_reg | drop;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    // entry: value, last, drop, set overflow
    assign ent_push = accept;
    assign ent_data = {value, last, drop, ovf_reg | drop};

endmodule

>>> rtl/gce_fifo.sv
module gce_fifo
    import gce_pkg::*;
#(
    parameter int W = 26
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic [W-1:0] wr_data,
    input  logic         rd_en,
    output logic [W-1:0] rd_data,
    output logic         full,
    output logic         empty
);
    localparam int PW = $clog2(FIFO_DEPTH);

    logic [W-1:0]  mem [FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   fill_reg;

    assign full    = (fill_reg == (PW+1)'(FIFO_DEPTH));
    assign empty   = (fill_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            fill_reg <= fill_reg + (PW+1)'(wr_en) - (PW+1)'(rd_en);
        end
    end

endmodule

>>> rtl/gce_back.sv
module gce_back
    import gce_pkg::*;
#(
    parameter int MAX_SAMPLES = 64,
    parameter int SAMPLE_BITS = 23,
    parameter int CW          = $clog2(MAX_SAMPLES + 1),
    parameter int EW          = SAMPLE_BITS + 3
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   ent_avail,
    input  logic [EW-1:0]          ent_data,
    output logic                   ent_pop,
    input  logic                   res_pop,
    output logic                   res_valid,
    output logic [GINI_W-1:0]      gini_q16,
    output logic [COUNT_OUT_W-1:0] sample_count,
    output logic                   overflow
);
    localparam int SW = SAMPLE_BITS + CW;
    localparam int TW = SAMPLE_BITS + 2 * CW;
    localparam int DW = SAMPLE_BITS + 2 * CW + 2;
    localparam int BW = $clog2(Q_FRAC_BITS);

    back_state_t state_reg, state_next;

    logic [SAMPLE_BITS-1:0] cell_reg  [MAX_SAMPLES];
    logic [SAMPLE_BITS-1:0] cell_next [MAX_SAMPLES];
    logic [MAX_SAMPLES-1:0] gt;

    logic [CW-1:0]          cnt_reg, k_reg;
    logic [SW-1:0]          p_reg;
    logic [TW-1:0]          t_reg;
    logic [DW-1:0]          m_reg, rem_reg, den_reg;
    logic [GINI_W-1:0]      q_reg;
    logic [BW-1:0]          bit_reg;
    logic                   ovf_reg;

    logic                   res_valid_reg;
    logic [GINI_W-1:0]      res_gini_reg;
    logic [COUNT_OUT_W-1:0] res_count_reg;
    logic                   res_ovf_reg;

    logic [SAMPLE_BITS-1:0] e_value;
    logic                   e_last, e_drop, e_ovf;
    logic                   insert;
    logic [DW-1:0]          two_t, num, den;
    logic                   trivial;
    logic [DW:0]            rem2;

    assign {e_value, e_last, e_drop, e_ovf} = ent_data;
    assign insert = ent_pop && !e_drop;

    // insertion row: strictly greater cells move up one place; the sweep shifts every cell down one place
    always_comb
    begin
        for (int i = 0; i < MAX_SAMPLES; i++)
            gt[i] = (CW'(i) < cnt_reg) && (cell_reg[i] > e_value);
        for (int i = 0; i < MAX_SAMPLES; i++)
        begin
            cell_next[i] = cell_reg[i];
            if (state_reg == B_SWEEP)
                cell_next[i] = (i == MAX_SAMPLES - 1) ? '0 : cell_reg[(i + 1) % MAX_SAMPLES];
            else if (insert)
            begin
                if (i > 0 && gt[(i + MAX_SAMPLES - 1) % MAX_SAMPLES])
                    cell_next[i] = cell_reg[(i + MAX_SAMPLES - 1) % MAX_SAMPLES];
                else if (gt[i] || CW'(i) == cnt_reg)
                    cell_next[i] = e_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_SAMPLES; i++)
            cell_reg[i] <= cell_next[i];
    end

    // final check: 2*w - (n+1)*s = m - 2*t, den = m - s
    always_comb
    begin
        two_t   = DW'({t_reg, 1'b0});
        num     = m_reg - two_t;
        den     = m_reg - DW'(p_reg);
        trivial = (p_reg == '0) || (m_reg <= two_t) || (num >= den);
        rem2    = {rem_reg, 1'b0};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:  if (ent_avail && e_last) state_next = B_SWEEP;
            B_SWEEP: if (k_reg == CW'(1)) state_next = B_FLUSH;
            B_FLUSH: state_next = B_MUL;
            B_MUL:   state_next = B_CHK;
            B_CHK:   state_next = trivial ? B_OUT : B_DIV;
            B_DIV:   if (bit_reg == BW'(Q_FRAC_BITS - 1)) state_next = B_OUT;
            B_OUT:   if (!res_valid_reg) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        ent_pop = (state_reg == B_IDLE) && ent_avail;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (insert)
                cnt_reg <= cnt_reg + CW'(1);
            else if (state_reg == B_OUT && !res_valid_reg)
                cnt_reg <= '0;
            if (state_reg == B_OUT && !res_valid_reg)
                res_valid_reg <= 1'b1;
            else if (res_pop)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                if (ent_pop && e_last)
                begin
                    ovf_reg <= e_ovf;
                    k_reg   <= insert ? cnt_reg + CW'(1) : cnt_reg;
                    p_reg   <= '0;
                    t_reg   <= '0;
                end
            end
            B_SWEEP:
            begin
                p_reg <= p_reg + SW'(cell_reg[0]);
                t_reg <= t_reg + TW'(p_reg);
                k_reg <= k_reg - CW'(1);
            end
            B_FLUSH: t_reg <= t_reg + TW'(p_reg);
            B_MUL:   m_reg <= DW'((CW+1)'(cnt_reg) + (CW+1)'(1)) * DW'(p_reg);
            B_CHK:
            begin
                rem_reg <= num;
                den_reg <= den;
                bit_reg <= '0;
                if (p_reg == '0 || m_reg <= two_t)
                    q_reg <= '0;
                else if (num >= den)
                    q_reg <= Q_ONE;
                else
                    q_reg <= '0;
            end
            B_DIV:
            begin
                bit_reg <= bit_reg + BW'(1);
                if (rem2 >= {1'b0, den_reg})
                begin
                    rem_reg <= DW'(rem2 - {1'b0, den_reg});
                    q_reg   <= {q_reg[GINI_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= DW'(rem2);
                    q_reg   <= {q_reg[GINI_W-2:0], 1'b0};
                end
            end
            B_OUT:
            begin
                if (!res_valid_reg)
                begin
                    res_gini_reg  <= q_reg;
                    res_count_reg <= COUNT_OUT_W'(cnt_reg);
                    res_ovf_reg   <= ovf_reg;
                end
            end
            default: ;
        endcase
    end

    assign res_valid    = res_valid_reg;
    assign gini_q16     = res_gini_reg;
    assign sample_count = res_count_reg;
    assign overflow     = res_ovf_reg;

endmodule

>>> rtl/gini_coefficient_engine.sv
// channel   | handshake          | payload
// ----------+--------------------+---------------------------------------
// input     | push / full        | sample[23:0] signed, last
// result    | pop / empty        | gini_q16[16:0], sample_count[6:0], overflow
//
// a sample transaction is inserted into the sorted row as the back end pops it, only while idle;
// a set's last transaction then runs the prefix-sum sweep, flush, multiply and check steps,
// then a restoring division (skipped when the result is 0 or 1) and a final output step
// the front keeps taking samples into a 4-entry queue while the back end works
// reset clears counts, flags, queue pointers and the result valid flag
// a waiting result holds the back end only at its final step
module gini_coefficient_engine
    import gce_pkg::*;
#(
    parameter int MAX_SAMPLES = 64,
    parameter int SAMPLE_BITS = 23
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [IN_W-1:0]        sample,
    input  logic                   last,
    output logic                   empty,
    input  logic                   pop,
    output logic [GINI_W-1:0]      gini_q16,
    output logic [COUNT_OUT_W-1:0] sample_count,
    output logic                   overflow
);
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int EW = SAMPLE_BITS + 3;

    logic          accept;
    logic          ent_push, ent_pop, q_empty, res_valid;
    logic [EW-1:0] ent_in, ent_out;

    // input transaction accepted
    assign accept = push && !full;

    // front: clamp the sample, track count and drops for the set
    gce_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CW          (CW),
        .EW          (EW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .sample   (sample),
        .last     (last),
        .ent_push (ent_push),
        .ent_data (ent_in)
    );

    // short queue decouples the front from the back end
    gce_fifo #(
        .W (EW)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ent_push),
        .wr_data (ent_in),
        .rd_en   (ent_pop),
        .rd_data (ent_out),
        .full    (full),
        .empty   (q_empty)
    );

    // back: sorted insertion row, prefix-sum sweep, divider, result register
    gce_back #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CW          (CW),
        .EW          (EW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .ent_avail    (!q_empty),
        .ent_data     (ent_out),
        .ent_pop      (ent_pop),
        .res_pop      (pop),
        .res_valid    (res_valid),
        .gini_q16     (gini_q16),
        .sample_count (sample_count),
        .overflow     (overflow)
    );

    assign empty = !res_valid;

    // result never exceeds 1.0
    a_gini_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> gini_q16 <= Q_ONE)
        else $error("gini result above one");

    // a set always holds at least one sample
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> sample_count != '0)
        else $error("result with zero samples");

    // overflow can only be reported for a set that filled the store
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && overflow) |-> sample_count == COUNT_OUT_W'(MAX_SAMPLES))
        else $error("overflow reported with store not full");

endmodule

>>> bench/gini_coefficient_engine_tb.sv
module gini_coefficient_engine_tb;
    import gce_pkg::*;

    localparam int CAPACITY    = 64;
    localparam int VALUE_BITS  = 23;
    localparam int RANDOM_ITEMS = 1750;
    localparam int CYCLE_LIMIT = 2000000;

    // one expected result transaction
    typedef struct packed {
        logic [GINI_W-1:0]      gini;
        logic [COUNT_OUT_W-1:0] count;
        logic                   ovf;
    } gini_result_t;

    // one directed stimulus row; expected fields used only when has_gold is set
    typedef struct {
        logic [IN_W-1:0]        value;
        logic                   is_last;
        logic                   has_gold;
        logic [GINI_W-1:0]      gold_gini;
        logic [COUNT_OUT_W-1:0] gold_count;
        logic                   gold_ovf;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   push;
    logic                   full;
    logic [IN_W-1:0]        sample;
    logic                   last;
    logic                   empty;
    logic                   pop;
    logic [GINI_W-1:0]      gini_q16;
    logic [COUNT_OUT_W-1:0] sample_count;
    logic                   overflow;

    gini_coefficient_engine uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .sample       (sample),
        .last         (last),
        .empty        (empty),
        .pop          (pop),
        .gini_q16     (gini_q16),
        .sample_count (sample_count),
        .overflow     (overflow)
    );

    // 10 unit clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state: sorted copy of the current set
    logic [VALUE_BITS-1:0] set_values [CAPACITY];
    int                    set_size;
    logic                  set_dropped;
    gini_result_t          pending_results [$];
    int                    error_count;
    int                    cycle_count;
    int                    pop_hold_max;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // truncated q1.16 gini of the sorted set
    function automatic logic [GINI_W-1:0] gini_of_set();
        logic [63:0] total;
        logic [63:0] weighted;
        logic [63:0] numer;
        logic [63:0] denom;
        logic [63:0] quot;
        logic [63:0] remain;
        total = 0;
        weighted = 0;
        if (set_size == 0)
            return '0;
        for (int i = 0; i < set_size; i++)
        begin
            total += set_values[i];
            weighted += 64'(i + 1) * set_values[i];
        end
        if (total == 0)
            return '0;
        if (2 * weighted <= 64'(set_size + 1) * total)
            return '0;
        numer = 2 * weighted - 64'(set_size + 1) * total;
        denom = 64'(set_size) * total;
        if (numer >= denom)
            return Q_ONE;
        quot = 0;
        remain = numer;
        for (int i = 0; i < Q_FRAC_BITS; i++)
        begin
            remain = remain << 1;
            quot = quot << 1;
            if (remain >= denom)
            begin
                remain -= denom;
                quot |= 1;
            end
        end
        if (quot > Q_ONE)
            quot = Q_ONE;
        return quot[GINI_W-1:0];
    endfunction

    // fold one accepted sample into the set, queue a result on the last one
    task automatic predict_sample(input logic [IN_W-1:0] value, input logic is_last);
        logic [VALUE_BITS-1:0] clipped;
        int                    pos;
        gini_result_t          res;
        // negatives count as zero, wide values saturate
        if (value[IN_W-1])
            clipped = '0;
        else if (value[IN_W-2:0] > {VALUE_BITS{1'b1}})
            clipped = {VALUE_BITS{1'b1}};
        else
            clipped = value[VALUE_BITS-1:0];
        if (set_size < CAPACITY)
        begin
            // equal values land after the stored ones
            pos = set_size;
            while (pos > 0 && set_values[pos-1] > clipped)
            begin
                set_values[pos] = set_values[pos-1];
                pos--;
            end
            set_values[pos] = clipped;
            set_size++;
        end
        else
            set_dropped = 1'b1;
        if (is_last)
        begin
            res.gini = gini_of_set();
            res.count = set_size[COUNT_OUT_W-1:0];
            res.ovf = set_dropped;
            pending_results.insert(pending_results.size(), res);
            set_size = 0;
            set_dropped = 1'b0;
        end
    endtask

    // mostly short gaps, now and then a long one
    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        else if (roll < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // drive one transaction and wait for it to be accepted
    task automatic send_sample(input logic [IN_W-1:0] value, input logic is_last);
        sample <= value;
        last <= is_last;
        push <= 1'b1;
        do
            @(posedge clk);
        while (full);
        predict_sample(value, is_last);
        @(negedge clk);
    endtask

    // random stimulus gaps: drop push only when idling
    task automatic sender_gap();
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // random sample: mix of zeros, negatives, small, huge
    function automatic logic [IN_W-1:0] random_sample();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return '0;
        else if (roll < 20)
            return {1'b1, 23'($urandom())};
        else if (roll < 50)
            return 24'($urandom_range(0, 15));
        else if (roll < 60)
            return {1'b0, {23{1'b1}}} - 24'($urandom_range(0, 3));
        else
            return {1'b0, 23'($urandom())};
    endfunction

    // set sizes: mostly short, some full, some past capacity
    function automatic int random_set_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return $urandom_range(1, 8);
        else if (roll < 85)
            return $urandom_range(9, 40);
        else if (roll < 93)
            return CAPACITY;
        else
            return $urandom_range(CAPACITY - 1, CAPACITY + 6);
    endfunction

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // result side: random pop stalls, checks each accepted transaction
    initial
    begin
        gini_result_t want;
        int           stall;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = idle_gap();
            if (stall > pop_hold_max)
                stall = pop_hold_max;
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            if (!empty)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("unexpected result, sample_count",
                                    32'(sample_count), 32'(0));
                else
                begin
                    want = pending_results.pop_front();
                    if (gini_q16 !== want.gini)
                        report_mismatch("gini_q16", 32'(gini_q16), 32'(want.gini));
                    if (sample_count !== want.count)
                        report_mismatch("sample_count", 32'(sample_count),
                                        32'(want.count));
                    if (overflow !== want.ovf)
                        report_mismatch("overflow", 32'(overflow), 32'(want.ovf));
                end
            end
        end
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // directed table: extremes, ties, zero set
    stim_row_t directed [$];

    task automatic add_row(input logic [IN_W-1:0] value, input logic is_last,
                           input logic has_gold, input logic [GINI_W-1:0] g,
                           input logic [COUNT_OUT_W-1:0] c, input logic o);
        stim_row_t row;
        row.value = value;
        row.is_last = is_last;
        row.has_gold = has_gold;
        row.gold_gini = g;
        row.gold_count = c;
        row.gold_ovf = o;
        directed.insert(directed.size(), row);
    endtask

    initial
    begin
        gini_result_t gold;
        int           items_sent;
        int           set_len;
        int           bursty;

        rst_n = 1'b0;
        push = 1'b0;
        sample = '0;
        last = 1'b0;
        set_size = 0;
        set_dropped = 1'b0;
        error_count = 0;
        pop_hold_max = 40;

        // single zero sample: all-zero set
        add_row(24'h000000, 1'b1, 1'b1, '0, 7'd1, 1'b0);
        // single most negative sample: counts as zero
        add_row(24'h800000, 1'b1, 1'b1, '0, 7'd1, 1'b0);
        // single largest sample: one value, gini 0
        add_row(24'h7fffff, 1'b1, 1'b1, '0, 7'd1, 1'b0);
        // negative then max: fully unequal pair gives 0.5
        add_row(24'hffffff, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(24'h7fffff, 1'b1, 1'b1, 17'h08000, 7'd2, 1'b0);
        // equal values, reverse order, mixed: predictor checked
        add_row(24'd5, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(24'd5, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(24'd5, 1'b1, 1'b0, '0, '0, 1'b0);
        add_row(24'd900, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(24'd30, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(24'h800001, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(24'd1, 1'b1, 1'b0, '0, '0, 1'b0);
        add_row(24'h555555, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(24'h2aaaaa, 1'b1, 1'b0, '0, '0, 1'b0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
        begin
            if (directed[i].has_gold && directed[i].is_last)
            begin
                // predictor must agree with the table value
                send_sample(directed[i].value, directed[i].is_last);
                gold = pending_results[$];
                if (gold.gini !== directed[i].gold_gini
                    || gold.count !== directed[i].gold_count
                    || gold.ovf !== directed[i].gold_ovf)
                    report_mismatch("directed row", i, 32'(directed[i].gold_gini));
            end
            else
                send_sample(directed[i].value, directed[i].is_last);
            sender_gap();
        end

        // full store plus two dropped samples, the last one dropped too
        for (int i = 0; i < CAPACITY + 2; i++)
            send_sample(24'(i * 3), i == CAPACITY + 1);
        push <= 1'b0;

        // hold off until every result has drained
        wait_drained();

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            set_len = random_set_size();
            bursty = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < set_len; k++)
            begin
                send_sample(random_sample(), k == set_len - 1);
                items_sent++;
                if (!bursty)
                    sender_gap();
            end
            if (items_sent > RANDOM_ITEMS / 2 && items_sent < RANDOM_ITEMS / 2 + 70)
            begin
                push <= 1'b0;
                wait_drained();
            end
        end
        push <= 1'b0;
        last <= 1'b0;

        wait_drained();
        repeat (200) @(negedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> gini_coefficient_engine.f
rtl/gce_pkg.sv
rtl/gce_front.sv
rtl/gce_fifo.sv
rtl/gce_back.sv
rtl/gini_coefficient_engine.sv
bench/gini_coefficient_engine_tb.sv
